/* hw/rtl/sorted_priority_queue_unit_defines.svh */
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Request and status codes, field widths and the cell broadcast bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W  = 32;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // Command and new entry sent to every cell in the chain.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] item;
        logic signed [DATA_W-1:0] prio;
    } spq_bcast_t;

endpackage

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry and decides locally whether to keep it, take the new entry,
// take the left neighbor's entry (insert shift) or the right one's (pop shift).
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                             clk,
    input  spq_pkg::spq_bcast_t              bcast,
    input  logic                             occ,
    input  logic                             head_stay,
    input  logic                             left_stay,
    input  logic signed [spq_pkg::DATA_W-1:0] left_item,
    input  logic signed [spq_pkg::DATA_W-1:0] left_prio,
    input  logic signed [spq_pkg::DATA_W-1:0] right_item,
    input  logic signed [spq_pkg::DATA_W-1:0] right_prio,
    output logic signed [spq_pkg::DATA_W-1:0] item,
    output logic signed [spq_pkg::DATA_W-1:0] prio,
    output logic                             stay
);

    logic signed [spq_pkg::DATA_W-1:0] item_reg;
    logic signed [spq_pkg::DATA_W-1:0] item_next;
    logic signed [spq_pkg::DATA_W-1:0] prio_reg;
    logic signed [spq_pkg::DATA_W-1:0] prio_next;
    logic                              take_new;

    // The head keeps its place unless the new priority is strictly greater.
    // Later cells keep theirs while their priority is strictly greater, and
    // since the list is sorted this only needs the head's decision as well.
    always_comb
    begin
        if (IS_HEAD)
        begin
            stay = occ && !(bcast.prio > prio_reg);
        end
        else
        begin
            stay = head_stay && occ && (prio_reg > bcast.prio);
        end
        take_new = left_stay && !stay;
    end

    // Next entry of this cell.
    always_comb
    begin
        item_next = item_reg;
        prio_next = prio_reg;
        priority if (bcast.rem)
        begin
            item_next = right_item;
            prio_next = right_prio;
        end
        else if (bcast.ins && !stay)
        begin
            if (take_new)
            begin
                item_next = bcast.item;
                prio_next = bcast.prio;
            end
            else
            begin
                item_next = left_item;
                prio_next = left_prio;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prio_reg <= prio_next;
    end

    assign item = item_reg;
    assign prio = prio_reg;

endmodule

/* hw/rtl/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded priority queue kept sorted, highest priority at the head, in a
// chain of cells that all place or shift their entry in the same cycle.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ----------------------------------------------
//  in       in_valid / in_stall  req_type, item_value, item_priority
//  out      out_valid/out_stall  out_item, out_priority, status, entry_count
//
// The whole cell chain compares and shifts in parallel, so one request is
// accepted per clock while in_stall is low, and its result appears in the
// output register on the next cycle.
// in_stall is raised only while a result is held in the output register and
// out_stall is high. Reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [spq_pkg::REQ_W-1:0]         req_type,
    input  logic signed [spq_pkg::DATA_W-1:0] item_value,
    input  logic signed [spq_pkg::DATA_W-1:0] item_priority,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [spq_pkg::DATA_W-1:0] out_item,
    output logic signed [spq_pkg::DATA_W-1:0] out_priority,
    output logic [spq_pkg::STAT_W-1:0]        status,
    output logic [spq_pkg::ENTRY_W-1:0]       entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                              accept;
    logic                              full;
    logic                              empty;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    spq_pkg::spq_bcast_t               bcast;

    logic signed [spq_pkg::DATA_W-1:0] cell_item [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] cell_prio [CAPACITY];
    logic                              cell_stay [CAPACITY];

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [spq_pkg::DATA_W-1:0] out_item_reg;
    logic signed [spq_pkg::DATA_W-1:0] out_item_next;
    logic signed [spq_pkg::DATA_W-1:0] out_prio_reg;
    logic signed [spq_pkg::DATA_W-1:0] out_prio_next;
    logic [spq_pkg::STAT_W-1:0]        status_reg;
    logic [spq_pkg::STAT_W-1:0]        status_next;
    logic [spq_pkg::ENTRY_W-1:0]       entry_count_reg;

    // Handshake: a new transaction enters unless a result is held back.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    // Decode the request into the chain command and the result fields.
    always_comb
    begin
        bcast.ins     = 1'b0;
        bcast.rem     = 1'b0;
        bcast.item    = item_value;
        bcast.prio    = item_priority;
        count_next    = count_reg;
        out_item_next = '0;
        out_prio_next = '0;
        status_next   = spq_pkg::ST_OK;
        unique case (req_type)
            spq_pkg::REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    bcast.ins  = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            spq_pkg::REQ_REMOVE, spq_pkg::REQ_PEEK:
            begin
                if (empty)
                begin
                    out_item_next = '1;
                    status_next   = spq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    out_item_next = cell_item[0];
                    out_prio_next = cell_prio[0];
                    if (req_type == spq_pkg::REQ_REMOVE)
                    begin
                        bcast.rem  = accept;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Cell chain: each cell sees its neighbors and the broadcast command.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                              occ;
            logic                              l_stay;
            logic signed [spq_pkg::DATA_W-1:0] l_item;
            logic signed [spq_pkg::DATA_W-1:0] l_prio;
            logic signed [spq_pkg::DATA_W-1:0] r_item;
            logic signed [spq_pkg::DATA_W-1:0] r_prio;

            assign occ = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign l_stay = 1'b1;
                assign l_item = '0;
                assign l_prio = '0;
            end
            else
            begin : g_mid
                assign l_stay = cell_stay[gi-1];
                assign l_item = cell_item[gi-1];
                assign l_prio = cell_prio[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign r_item = '0;
                assign r_prio = '0;
            end
            else
            begin : g_inner
                assign r_item = cell_item[gi+1];
                assign r_prio = cell_prio[gi+1];
            end

            spq_cell #(
                .IS_HEAD    (gi == 0)
            ) u_cell (
                .clk        (clk),
                .bcast      (bcast),
                .occ        (occ),
                .head_stay  (cell_stay[0]),
                .left_stay  (l_stay),
                .left_item  (l_item),
                .left_prio  (l_prio),
                .right_item (r_item),
                .right_prio (r_prio),
                .item       (cell_item[gi]),
                .prio       (cell_prio[gi]),
                .stay       (cell_stay[gi])
            );
        end
    endgenerate

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // Output register valid flag.
    always_comb
    begin
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded with each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg    <= out_item_next;
            out_prio_reg    <= out_prio_next;
            status_reg      <= status_next;
            entry_count_reg <= spq_pkg::ENTRY_W'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_item     = out_item_reg;
    assign out_priority = out_prio_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;

    // Checks on the queue bookkeeping and ordering.
    `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_insert_grows, accept && bcast.ins, count_reg == $past(count_reg) + CNT_W'(1))
    `SPQ_ASSERT_NEXT(a_pop_returns_head, accept && bcast.rem, out_item == $past(cell_item[0]) && out_priority == $past(cell_prio[0]))
    `SPQ_ASSERT_SAME(a_full_drop, accept && status_next == spq_pkg::ST_FULL, full && !bcast.ins)

endmodule
